// ===== design/dpr_pkg.sv =====
`timescale 1ns / 1ps

package dpr_pkg;

  localparam int VALUE_W  = 32;
  localparam int DIGITS_W = 8;
  localparam int MODE_W   = 2;
  localparam int DIDX_W   = 4;
  localparam int POW_W    = 34;  // 10^10 needs 34 bits
  localparam int RECIP_W  = 29;  // floor(2^32 / 10) needs 29 bits

  localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UP      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOWN    = 2'd2;

  localparam logic [DIGITS_W-1:0] DIGITS_MIN = 8'd1;
  localparam logic [DIGITS_W-1:0] DIGITS_MAX = 8'd10;

  // Stage 1 to modulo pipeline.
  typedef struct packed {
    logic                neg;
    logic [MODE_W-1:0]   mode;
    logic [VALUE_W-1:0]  mag;
    logic [POW_W-1:0]    pow;
    logic [RECIP_W-1:0]  recip;
  } front_t;

  // Modulo pipeline to round stage.
  typedef struct packed {
    logic                neg;
    logic [MODE_W-1:0]   mode;
    logic [VALUE_W-1:0]  mag;
    logic [POW_W-1:0]    pow;
    logic [VALUE_W-1:0]  rem;
  } modres_t;

  function automatic logic [POW_W-1:0] pow10(input logic [DIDX_W-1:0] d);
    logic [POW_W-1:0] p;
    case (d)
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = 34'd10000000000;
    endcase
    return p;
  endfunction

  // floor(2^32 / 10^d); the quotient estimate is then low by at most one.
  function automatic logic [RECIP_W-1:0] recip10(input logic [DIDX_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd1:    r = 29'd429496729;
      4'd2:    r = 29'd42949672;
      4'd3:    r = 29'd4294967;
      4'd4:    r = 29'd429496;
      4'd5:    r = 29'd42949;
      4'd6:    r = 29'd4294;
      4'd7:    r = 29'd429;
      4'd8:    r = 29'd42;
      4'd9:    r = 29'd4;
      default: r = 29'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/decimal_place_rounder.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Bus          Fields (lowest bit up)
// s_axis    in   tdata[39:0]  value[31:0], digits[39:32]
//                tuser[1:0]   mode[1:0]
// m_axis    out  tdata[31:0]  rounded[31:0]
//                tuser[0]     overflow
//
// One beat in and one beat out per cycle while the output is not stalled;
// each accepted input beat passes to the output register through the
// five-stage pipeline: decode, reciprocal multiply, quotient-times-power
// multiply, remainder correction, round and saturate.
// rst is synchronous and clears only the stage valid bits.
// A stalled output holds its beat; each stage takes a new beat whenever it
// is empty or the stage after it advances, so bubbles close up under stall.

module decimal_place_rounder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], digits[39:32]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // rounded[31:0]
  output logic        m_tuser    // overflow
);
  import dpr_pkg::*;

  front_t  front_data;
  modres_t mod_data;
  logic    front_valid, front_ready;
  logic    mod_valid, mod_ready;

  // Stage 1: clamp digits, take magnitude, look up power and reciprocal.
  dpr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .value     (s_tdata[VALUE_W-1:0]),
    .mode      (s_tuser[MODE_W-1:0]),
    .digits    (s_tdata[VALUE_W+DIGITS_W-1:VALUE_W]),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  // Stages 2-4: remainder of the magnitude by the selected power of ten,
  // via a reciprocal quotient estimate and a single correction.
  dpr_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (mod_valid),
    .out_ready (mod_ready),
    .out_data  (mod_data)
  );

  // Stage 5: pick the direction, restore the sign, saturate.
  dpr_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mod_valid),
    .in_ready  (mod_ready),
    .in_data   (mod_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .rounded   (m_tdata),
    .overflow  (m_tuser)
  );

endmodule

// ===== design/dpr_front.sv =====
`timescale 1ns / 1ps

module dpr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dpr_pkg::VALUE_W-1:0]  value,
  input  logic [dpr_pkg::MODE_W-1:0]   mode,
  input  logic [dpr_pkg::DIGITS_W-1:0] digits,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dpr_pkg::front_t              out_data
);
  import dpr_pkg::*;

  logic [DIGITS_W-1:0] dclamp;
  logic [DIDX_W-1:0]   didx;
  logic                neg;
  logic [VALUE_W-1:0]  mag;

  always_comb begin
    if (digits < DIGITS_MIN) begin
      dclamp = DIGITS_MIN;
    end else if (digits > DIGITS_MAX) begin
      dclamp = DIGITS_MAX;
    end else begin
      dclamp = digits;
    end
    didx = dclamp[DIDX_W-1:0];
    neg  = value[VALUE_W-1];
    // Magnitude of the most negative value is 2^31, exact in 32 unsigned bits.
    mag  = neg ? (~value + 32'd1) : value;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.neg   <= neg;
      out_data.mode  <= mode;
      out_data.mag   <= mag;
      out_data.pow   <= pow10(didx);
      out_data.recip <= recip10(didx);
    end
  end

endmodule

// ===== design/dpr_mod.sv =====
`timescale 1ns / 1ps

module dpr_mod (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dpr_pkg::front_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dpr_pkg::modres_t out_data
);
  import dpr_pkg::*;

  localparam int PROD_W = VALUE_W + RECIP_W;

  // Stage 2: quotient estimate
  logic               v2;
  logic               neg2;
  logic [MODE_W-1:0]  mode2;
  logic [VALUE_W-1:0] mag2;
  logic [POW_W-1:0]   pow2;
  logic [RECIP_W-1:0] q2;
  // Stage 3: quotient times power
  logic               v3;
  logic               neg3;
  logic [MODE_W-1:0]  mode3;
  logic [VALUE_W-1:0] mag3;
  logic [POW_W-1:0]   pow3;
  logic [VALUE_W-1:0] qp3;

  logic               r2, r3, r4;
  logic [PROD_W-1:0]  prod1;
  logic [VALUE_W-1:0] prod2;
  logic [VALUE_W-1:0] rem_raw;
  logic [VALUE_W-1:0] rem_fix;

  assign r4       = !out_valid || out_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign in_ready = r2;

  assign prod1 = PROD_W'(in_data.mag) * PROD_W'(in_data.recip);
  // q2 never exceeds the true quotient, so q2 * pow <= mag fits 32 bits.
  assign prod2 = {{(VALUE_W-RECIP_W){1'b0}}, q2} * pow2[VALUE_W-1:0];

  always_comb begin
    rem_raw = mag3 - qp3;
    // Correct an estimate that fell one short.
    if ({{(POW_W-VALUE_W){1'b0}}, rem_raw} >= pow3) begin
      rem_fix = rem_raw - pow3[VALUE_W-1:0];
    end else begin
      rem_fix = rem_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r2) v2 <= in_valid;
      if (r3) v3 <= v2;
      if (r4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && r2) begin
      neg2  <= in_data.neg;
      mode2 <= in_data.mode;
      mag2  <= in_data.mag;
      pow2  <= in_data.pow;
      q2    <= prod1[PROD_W-1:VALUE_W];
    end
    if (v2 && r3) begin
      neg3  <= neg2;
      mode3 <= mode2;
      mag3  <= mag2;
      pow3  <= pow2;
      qp3   <= prod2;
    end
    if (v3 && r4) begin
      out_data.neg  <= neg3;
      out_data.mode <= mode3;
      out_data.mag  <= mag3;
      out_data.pow  <= pow3;
      out_data.rem  <= rem_fix;
    end
  end

endmodule

// ===== design/dpr_round.sv =====
`timescale 1ns / 1ps

module dpr_round (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dpr_pkg::modres_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dpr_pkg::VALUE_W-1:0] rounded,
  output logic                        overflow
);
  import dpr_pkg::*;

  localparam int RES_W = POW_W + 1;

  logic [VALUE_W-1:0] floor_m;
  logic [POW_W-1:0]   half;
  logic               up;
  logic [RES_W-1:0]   res_m;
  logic [VALUE_W-1:0] rnd;
  logic               ovf;

  always_comb begin
    floor_m = in_data.mag - in_data.rem;
    half    = in_data.pow >> 1;
    case (in_data.mode)
      MODE_UP:   up = !in_data.neg;
      MODE_DOWN: up = in_data.neg;
      default:   up = {{(POW_W-VALUE_W){1'b0}}, in_data.rem} >= half;
    endcase
    res_m = RES_W'(floor_m);
    if (up && (in_data.rem != '0)) begin
      res_m = res_m + RES_W'(in_data.pow);
    end
    ovf = 1'b0;
    if (in_data.neg) begin
      if (res_m > RES_W'(32'h8000_0000)) begin
        rnd = 32'h8000_0000;
        ovf = 1'b1;
      end else begin
        rnd = 32'd0 - res_m[VALUE_W-1:0];
      end
    end else begin
      if (res_m > RES_W'(32'h7FFF_FFFF)) begin
        rnd = 32'h7FFF_FFFF;
        ovf = 1'b1;
      end else begin
        rnd = res_m[VALUE_W-1:0];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rounded  <= rnd;
      overflow <= ovf;
    end
  end

endmodule

// ===== design/dpr_checker.sv =====
`timescale 1ns / 1ps

module dpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // Hold a stalled output beat.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed under stall");

  // Overflow always comes with a saturated value.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == 32'h7FFF_FFFF) || (m_tdata == 32'h8000_0000))
    else $error("overflow without saturated result");

  // A free output lets every stage advance, so the input must be ready.
  a_flow: assert property (@(posedge clk)
    m_tready |-> s_tready)
    else $error("input stalled while output is free");

  // Drop all beats in flight on reset.
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind decimal_place_rounder dpr_checker u_dpr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== verif/decimal_place_rounder_test.sv =====
`timescale 1ns / 1ps

module decimal_place_rounder_test;
  import dpr_pkg::*;

  // Mode 3 is not a defined mode; the block treats it as nearest.
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
  localparam int HANG_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 10;
  localparam int RANDOM_ITEMS = 525;

  // Expected results of accepted beats, oldest first, plus the checker.
  class rounding_scoreboard;
    typedef struct {
      logic [VALUE_W-1:0] rounded;
      logic               overflow;
    } rounding_t;

    rounding_t expected_q[$];
    int mismatches = 0;
    int beats_in = 0;
    int results_checked = 0;
    int overflows = 0;

    static function longint unsigned decade(int unsigned d);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < d; i++) p = p * 10;
      return p;
    endfunction

    static function int unsigned clamp_digits(logic [DIGITS_W-1:0] digits);
      if (digits < DIGITS_MIN) return DIGITS_MIN;
      if (digits > DIGITS_MAX) return DIGITS_MAX;
      return digits;
    endfunction

    // Round on the magnitude, then put the sign back and saturate.
    function rounding_t round_to_decade(logic [VALUE_W-1:0] value,
                                        logic [MODE_W-1:0] mode,
                                        logic [DIGITS_W-1:0] digits);
      rounding_t       r;
      logic            neg;
      logic            up;
      longint unsigned mag;
      longint unsigned step;
      longint unsigned rem;
      longint unsigned res;
      neg  = value[VALUE_W-1];
      mag  = neg ? {32'd0, ~value} + 64'd1 : {32'd0, value};
      step = decade(clamp_digits(digits));
      rem  = mag % step;
      case (mode)
        MODE_UP:   up = !neg;
        MODE_DOWN: up = neg;
        default:   up = rem >= step / 2;
      endcase
      res = (up && rem != 0) ? mag - rem + step : mag - rem;
      r.overflow = 1'b0;
      if (neg) begin
        if (res > 64'h8000_0000) begin
          r.rounded  = 32'h8000_0000;
          r.overflow = 1'b1;
        end else begin
          r.rounded = 32'd0 - res[31:0];
        end
      end else begin
        if (res > 64'h7FFF_FFFF) begin
          r.rounded  = 32'h7FFF_FFFF;
          r.overflow = 1'b1;
        end else begin
          r.rounded = res[31:0];
        end
      end
      return r;
    endfunction

    function void note_input(logic [VALUE_W-1:0] value, logic [MODE_W-1:0] mode,
                             logic [DIGITS_W-1:0] digits);
      expected_q.push_back(round_to_decade(value, mode, digits));
      beats_in++;
    endfunction

    function void check_result(logic [VALUE_W-1:0] rounded, logic overflow);
      rounding_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result rounded=%0d overflow=%0b", $time,
                 $signed(rounded), overflow);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (overflow) overflows++;
      if (rounded !== want.rounded) begin
        $display("%0t: rounded expected %0d actual %0d", $time,
                 $signed(want.rounded), $signed(rounded));
        mismatches++;
      end
      if (overflow !== want.overflow) begin
        $display("%0t: overflow expected %0b actual %0b", $time,
                 want.overflow, overflow);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // value[31:0], digits[39:32]
  logic [1:0]  s_tuser;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // rounded[31:0]
  logic        m_tuser;   // overflow

  rounding_scoreboard sb = new;
  int idle_cycles = 0;
  int send_calm = 0;
  int recv_calm = 0;

  decimal_place_rounder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Note accepted beats on both sides at the edge that moves them.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_input(s_tdata[31:0], s_tuser, s_tdata[39:32]);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tuser);
  end

  // Stop a hung run: count cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, HANG_LIMIT);
      $display("decimal_place_rounder test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall a random number of cycles before each result, with
  // occasional runs of back-to-back acceptance.
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      if (recv_calm > 0) begin
        recv_calm--;
        stall = 0;
      end else begin
        if ($urandom_range(0, 15) == 0) recv_calm = $urandom_range(10, 40);
        stall = $urandom_range(0, 16);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  // Present one beat after a random gap and hold it until accepted.
  // tvalid stays high after acceptance; a zero gap keeps it high.
  task automatic send_beat(logic [VALUE_W-1:0] value, logic [MODE_W-1:0] mode,
                           logic [DIGITS_W-1:0] digits);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(10, 40);
      gap = $urandom_range(0, 16);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {digits, value};
    s_tuser  <= mode;
    do @(posedge clk); while (s_tready !== 1'b1);
  endtask

  // Drop tvalid and hold off until every expected result is back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    logic [VALUE_W-1:0]  value;
    logic [MODE_W-1:0]   mode;
    logic [DIGITS_W-1:0] digits;
    longint unsigned     step;
    longint unsigned     mult;
    longint unsigned     offset;
    longint unsigned     near;
    int                  pick;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = MODE_NEAREST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, signs, halves, digit clamping, mode 3, saturation.
    send_beat(32'd0,           MODE_NEAREST,  8'd1);
    send_beat(32'd0,           MODE_UP,       8'd10);
    send_beat(32'd15,          MODE_NEAREST,  8'd0);
    send_beat(-32'sd15,        MODE_NEAREST,  8'd1);
    send_beat(32'd14,          MODE_NEAREST,  8'd1);
    send_beat(32'd500,         MODE_NEAREST,  8'd3);
    send_beat(-32'sd500,       MODE_NEAREST,  8'd3);
    send_beat(32'd499,         MODE_NEAREST,  8'd3);
    send_beat(32'd1,           MODE_UP,       8'd1);
    send_beat(-32'sd1,         MODE_UP,       8'd1);
    send_beat(32'd1,           MODE_DOWN,     8'd1);
    send_beat(-32'sd1,         MODE_DOWN,     8'd1);
    send_beat(32'd25,          MODE_RESERVED, 8'd1);
    send_beat(-32'sd25,        MODE_RESERVED, 8'd1);
    send_beat(32'h7FFF_FFFF,   MODE_UP,       8'd1);
    send_beat(32'h7FFF_FFFF,   MODE_NEAREST,  8'd9);
    send_beat(32'h7FFF_FFFF,   MODE_NEAREST,  8'd10);
    send_beat(32'h7FFF_FFFF,   MODE_UP,       8'd255);
    send_beat(32'h8000_0000,   MODE_DOWN,     8'd1);
    send_beat(32'h8000_0000,   MODE_NEAREST,  8'd11);
    send_beat(32'h8000_0000,   MODE_UP,       8'd9);
    send_beat(-32'sd1,         MODE_DOWN,     8'd10);
    send_beat(32'd1999999999,  MODE_NEAREST,  8'd9);
    send_beat(32'd1234567890,  MODE_DOWN,     8'd128);
    send_beat(-32'sd999999999, MODE_UP,       8'd255);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      digits = 8'd0;
      else if (pick == 1) digits = DIGITS_W'($urandom_range(11, 255));
      else if (pick == 2) digits = DIGITS_W'($urandom);
      else                digits = DIGITS_W'($urandom_range(DIGITS_MIN, DIGITS_MAX));

      mode = ($urandom_range(0, 15) == 0)
             ? MODE_RESERVED
             : MODE_W'($urandom_range(MODE_NEAREST, MODE_DOWN));

      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        value = $urandom;
      end else if (pick < 9) begin
        // Land on or next to a multiple of the power, halves included.
        step = rounding_scoreboard::decade(rounding_scoreboard::clamp_digits(digits));
        mult = {32'd0, $urandom} % (64'h1_0000_0000 / step + 1);
        case ($urandom_range(0, 6))
          0:       offset = 0;
          1:       offset = step / 2;
          2:       offset = step / 2 - 1;
          3:       offset = step / 2 + 1;
          4:       offset = 1;
          5:       offset = step - 1;
          default: offset = {32'd0, $urandom} % step;
        endcase
        near  = mult * step + offset;
        value = near[31:0];
        if ($urandom_range(0, 1) == 1) value = 32'd0 - value;
      end else begin
        // Close to either int32 limit.
        value = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF - $urandom_range(0, 20)
                                            : 32'h8000_0000 + $urandom_range(0, 20);
      end

      send_beat(value, mode, digits);
      if (n % 150 == 149) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Rounded %0d beats (directed limits, halves, clamped digits, all modes)",
             sb.beats_in);
    $display("and checked %0d results, %0d of them saturated with overflow",
             sb.results_checked, sb.overflows);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("decimal_place_rounder test passed");
    end else begin
      $display("decimal_place_rounder test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dpr_pkg.sv
design/dpr_front.sv
design/dpr_mod.sv
design/dpr_round.sv
design/decimal_place_rounder.sv
design/dpr_checker.sv
verif/decimal_place_rounder_test.sv
